// ===== src/bpc_pkg.sv =====
// Shared types and constants for the barometric pressure compensation core.
// No dependencies; imported by bpc_div and the top level.
package bpc_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_TEMP   = 2'd0,
        CFG_PLOW   = 2'd1,
        CFG_PHIGH  = 2'd2,
        CFG_P9     = 2'd3
    } t_cfg_idx;

    localparam int REM_W   = 40;   // divider remainder and divisor width
    localparam int QHI_W   = 36;   // integer quotient bits
    localparam int QLO_W   = 12;   // scaled remainder quotient bits

    localparam logic signed [25:0] FINE_OFFSET = 26'sd128000;
    localparam logic [11:0]        DIV_SCALE   = 12'd3125;
    localparam logic [36:0]        QUOT_CLAMP  = 37'h10_0000_0000;

    // Per-item data that rides alongside the divider
    typedef struct packed {
        logic signed [15:0] tc;
        logic signed [24:0] tfine;
        logic               neg;
        logic               bad;
        logic               sat;
        logic [47:0]        qk;
    } t_side;

endpackage

// ===== src/bpc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on bpc_pkg for the side-data struct.
module bpc_div #(
    parameter int QW = 36,
    parameter int RW = 40
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  logic [RW-1:0]       i_dvs,
    input  logic [RW-1:0]       i_rem,
    input  logic [QW-1:0]       i_low,
    input  bpc_pkg::t_side      i_side,
    output logic                o_vld,
    output logic [QW-1:0]       o_quo,
    output logic [RW-1:0]       o_rem,
    output logic [RW-1:0]       o_dvs,
    output bpc_pkg::t_side      o_side
);
    import bpc_pkg::*;

    logic          s_vld  [QW+1];
    logic [RW-1:0] s_rem  [QW+1];
    logic [RW-1:0] s_dvs  [QW+1];
    logic [QW-1:0] s_low  [QW+1];
    logic [QW-1:0] s_quo  [QW+1];
    t_side         s_side [QW+1];

    assign s_vld[0]  = i_vld;
    assign s_rem[0]  = i_rem;
    assign s_dvs[0]  = i_dvs;
    assign s_low[0]  = i_low;
    assign s_quo[0]  = '0;
    assign s_side[0] = i_side;

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic          r_vld;
        logic [RW-1:0] r_rem;
        logic [RW-1:0] r_dvs;
        logic [QW-1:0] r_low;
        logic [QW-1:0] r_quo;
        t_side         r_side;
        logic [RW-1:0] trial;
        logic          ge;

        // shift in the next dividend bit, subtract when it fits
        assign trial = {s_rem[k][RW-2:0], s_low[k][QW-1]};
        assign ge    = (trial >= s_dvs[k]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= s_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= ge ? (trial - s_dvs[k]) : trial;
                r_dvs  <= s_dvs[k];
                r_low  <= {s_low[k][QW-2:0], 1'b0};
                r_quo  <= {s_quo[k][QW-2:0], ge};
                r_side <= s_side[k];
            end
        end

        assign s_vld[k+1]  = r_vld;
        assign s_rem[k+1]  = r_rem;
        assign s_dvs[k+1]  = r_dvs;
        assign s_low[k+1]  = r_low;
        assign s_quo[k+1]  = r_quo;
        assign s_side[k+1] = r_side;
    end

    assign o_vld  = s_vld[QW];
    assign o_quo  = s_quo[QW];
    assign o_rem  = s_rem[QW];
    assign o_dvs  = s_dvs[QW];
    assign o_side = s_side[QW];

endmodule

// ===== src/barometric_pressure_compensation_core.sv =====
// Top level of the barometric pressure compensation core.
// Depends on bpc_pkg and bpc_div.
//
// Usage:
//   Slave stream carries one raw sample per request: six bytes from the
//   sensor's result registers. The master stream returns compensated
//   temperature (0.01 degC), fine temperature and pressure (Pa, Q24.8),
//   with tuser flagging a zero pressure divisor (pressure then 0).
//   Calibration words come in through the write port (index 0: T1..T3,
//   1: P1..P4, 2: P5..P8, 3: P9); write them only while the core is idle.
// Throughput: one request per cycle, sustained while the master side accepts results.
// Pipeline: 11 stages of multiply/accumulate front end, 36 stages of
//   integer-quotient division, one scaling stage, 12 stages of fractional
//   division, 5 stages of the second-order correction and saturation.
//   The divider bit stages set the depth.
// Reset: synchronous active low; clears all valid bits and calibration
//   words, so the pipeline comes up empty.
// Stall: while a result waits on the master side, the whole pipeline
//   holds and s_axis_tready drops; nothing is lost or repeated.
module barometric_pressure_compensation_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    // raw sample in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // press_msb, press_lsb, press_xlsb, temp_msb, temp_lsb, temp_xlsb
    input  logic [47:0] s_axis_tdata,
    // compensated result out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // temp_centi[15:0], fine_temp[47:16], pressure_q8[79:48]
    output logic [79:0] m_axis_tdata,
    // invalid
    output logic [0:0]  m_axis_tuser
);
    import bpc_pkg::*;

    // ---------------- configuration ----------------
    logic [47:0] r_tcf;
    logic [63:0] r_plo;
    logic [63:0] r_phi;
    logic [15:0] r_p9;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tcf <= '0;
            r_plo <= '0;
            r_phi <= '0;
            r_p9  <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_TEMP:  r_tcf <= i_cfg_data[47:0];
                CFG_PLOW:  r_plo <= i_cfg_data;
                CFG_PHIGH: r_phi <= i_cfg_data;
                CFG_P9:    r_p9  <= i_cfg_data[15:0];
                default:   r_p9  <= r_p9;
            endcase
        end
    end

    logic signed [15:0] w_t2, w_t3, w_p2, w_p3, w_p4, w_p5, w_p6, w_p7, w_p8, w_p9;
    logic signed [16:0] w_p1;
    assign w_t2 = $signed(r_tcf[31:16]);
    assign w_t3 = $signed(r_tcf[47:32]);
    assign w_p1 = $signed({1'b0, r_plo[15:0]});
    assign w_p2 = $signed(r_plo[31:16]);
    assign w_p3 = $signed(r_plo[47:32]);
    assign w_p4 = $signed(r_plo[63:48]);
    assign w_p5 = $signed(r_phi[15:0]);
    assign w_p6 = $signed(r_phi[31:16]);
    assign w_p7 = $signed(r_phi[47:32]);
    assign w_p8 = $signed(r_phi[63:48]);
    assign w_p9 = $signed(r_p9);

    // ---------------- flow control ----------------
    // Advance every stage together; hold all when the output waits.
    logic       w_en;
    logic [11:1] r_vld_s;
    logic        r_vld_x;
    logic [5:1]  r_vld_p;
    logic        w_d1_vld, w_d2_vld;

    assign w_en          = !r_vld_p[5] || m_axis_tready;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_s <= '0;
            r_vld_x <= 1'b0;
            r_vld_p <= '0;
        end else if (w_en) begin
            r_vld_s <= {r_vld_s[10:1], s_axis_tvalid};
            r_vld_x <= w_d1_vld;
            r_vld_p <= {r_vld_p[4:1], w_d2_vld};
        end
    end

    // ---------------- front end: temperature ----------------
    logic [19:0] w_adc_p, w_adc_t;
    assign w_adc_p = {s_axis_tdata[7:0],   s_axis_tdata[15:8],  s_axis_tdata[23:20]};
    assign w_adc_t = {s_axis_tdata[31:24], s_axis_tdata[39:32], s_axis_tdata[47:44]};

    logic signed [17:0] r1_tx;
    logic signed [16:0] r1_te;
    logic [19:0]        r_adcp [1:8];
    logic signed [33:0] r2_m1, r2_ee;
    logic signed [22:0] r3_v1;
    logic signed [37:0] r3_v2m;
    logic signed [24:0] r4_tfine;
    logic signed [25:0] r5_pv1;
    logic signed [27:0] n5_t;
    logic signed [15:0] n5_tc;
    t_side              r_side [5:10];
    t_side              r11_side;

    always_comb begin
        n5_t = (28'(r4_tfine) * 28'sd5 + 28'sd128) >>> 8;
        if (n5_t > 28'sd32767) begin
            n5_tc = 16'sh7fff;
        end else if (n5_t < -28'sd32768) begin
            n5_tc = 16'sh8000;
        end else begin
            n5_tc = 16'(n5_t);
        end
    end

    // ---------------- front end: pressure terms ----------------
    logic signed [47:0] r6_sq;
    logic signed [41:0] r6_v1p5, r6_v1p2, r7_v1p5, r7_v1p2;
    logic signed [63:0] r7_sqp6, r7_sqp3;
    logic signed [63:0] r8_v2, r8_a;
    logic signed [47:0] r9_ahp1;
    logic [48:0]        r9_alp1;
    logic signed [63:0] r9_n;
    logic signed [47:0] r10_d;
    logic [63:0]        r10_m;
    logic               r10_nneg;
    logic [REM_W-1:0]   r11_ad, r11_rem;
    logic [QHI_W-1:0]   r11_low;
    logic [REM_W-1:0]   n11_ad;
    t_side              n11_side;

    assign n11_ad = r10_d[47] ? 40'(-r10_d) : 40'(r10_d);

    // sign, zero divisor and quotient overflow ride with the side data
    always_comb begin
        n11_side     = r_side[10];
        n11_side.neg = r10_nneg ^ r10_d[47];
        n11_side.bad = (r10_d == '0);
        n11_side.sat = ({12'b0, r10_m[63:36]} >= n11_ad);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // stage 1: unpack raw words, first differences
            r1_tx     <= $signed({1'b0, w_adc_t[19:3]}) - $signed({1'b0, r_tcf[15:0], 1'b0});
            r1_te     <= $signed({1'b0, w_adc_t[19:4]}) - $signed({1'b0, r_tcf[15:0]});
            r_adcp[1] <= w_adc_p;
            for (int k = 2; k <= 8; k++) begin
                r_adcp[k] <= r_adcp[k-1];
            end
            // stage 2
            r2_m1 <= r1_tx * w_t2;
            r2_ee <= r1_te * r1_te;
            // stage 3
            r3_v1  <= 23'(r2_m1 >>> 11);
            r3_v2m <= $signed({1'b0, r2_ee[32:12]}) * w_t3;
            // stage 4: fine temperature
            r4_tfine <= 25'(r3_v1) + 25'(r3_v2m >>> 14);
            // stage 5
            r5_pv1         <= 26'(r4_tfine) - FINE_OFFSET;
            r_side[5].tc    <= n5_tc;
            r_side[5].tfine <= r4_tfine;
            r_side[5].neg   <= 1'b0;
            r_side[5].bad   <= 1'b0;
            r_side[5].sat   <= 1'b0;
            r_side[5].qk    <= '0;
            for (int k = 6; k <= 10; k++) begin
                r_side[k] <= r_side[k-1];
            end
            // stage 6
            r6_sq   <= 48'(r5_pv1 * r5_pv1);
            r6_v1p5 <= r5_pv1 * w_p5;
            r6_v1p2 <= r5_pv1 * w_p2;
            // stage 7
            r7_sqp6 <= r6_sq * w_p6;
            r7_sqp3 <= r6_sq * w_p3;
            r7_v1p5 <= r6_v1p5;
            r7_v1p2 <= r6_v1p2;
            // stage 8: numerator offset and divisor seed
            r8_v2 <= r7_sqp6 + (64'(r7_v1p5) <<< 17) + (64'(w_p4) <<< 35);
            r8_a  <= 64'sh0000_8000_0000_0000 + (r7_sqp3 >>> 8) + (64'(r7_v1p2) <<< 12);
            // stage 9: divisor halves times P1, numerator
            r9_ahp1 <= $signed(r8_a[63:33]) * w_p1;
            r9_alp1 <= r8_a[32:0] * r_plo[15:0];
            r9_n    <= $signed({12'b0, 21'h10_0000 - {1'b0, r_adcp[8]}, 31'b0}) - r8_v2;
            // stage 10
            r10_d    <= r9_ahp1 + $signed({32'b0, r9_alp1[48:33]});
            r10_m    <= r9_n[63] ? 64'(-r9_n) : 64'(r9_n);
            r10_nneg <= r9_n[63];
            // stage 11: magnitude, zero check, quotient overflow check
            r11_ad   <= n11_ad;
            r11_rem  <= {12'b0, r10_m[63:36]};
            r11_low  <= r10_m[35:0];
            r11_side <= n11_side;
        end
    end

    // ---------------- integer quotient ----------------
    logic [QHI_W-1:0] w_d1_quo;
    logic [REM_W-1:0] w_d1_rem, w_d1_dvs;
    t_side            w_d1_side;

    bpc_div #(.QW(QHI_W), .RW(REM_W)) u_div_hi (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (r_vld_s[11]),
        .i_dvs  (r11_ad),
        .i_rem  (r11_rem),
        .i_low  (r11_low),
        .i_side (r11_side),
        .o_vld  (w_d1_vld),
        .o_quo  (w_d1_quo),
        .o_rem  (w_d1_rem),
        .o_dvs  (w_d1_dvs),
        .o_side (w_d1_side)
    );

    // scale stage: quotient and remainder times 3125
    logic [51:0]      r_x_x;
    logic [REM_W-1:0] r_x_dvs;
    t_side            r_x_side;
    t_side            n_x_side;

    always_comb begin
        n_x_side    = w_d1_side;
        n_x_side.qk = w_d1_quo * DIV_SCALE;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x_x    <= w_d1_rem * DIV_SCALE;
            r_x_dvs  <= w_d1_dvs;
            r_x_side <= n_x_side;
        end
    end

    // ---------------- fractional quotient ----------------
    logic [QLO_W-1:0] w_d2_quo;
    logic [REM_W-1:0] w_d2_rem, w_d2_dvs;
    t_side            w_d2_side;

    bpc_div #(.QW(QLO_W), .RW(REM_W)) u_div_lo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (r_vld_x),
        .i_dvs  (r_x_dvs),
        .i_rem  (r_x_x[51:12]),
        .i_low  (r_x_x[11:0]),
        .i_side (r_x_side),
        .o_vld  (w_d2_vld),
        .o_quo  (w_d2_quo),
        .o_rem  (w_d2_rem),
        .o_dvs  (w_d2_dvs),
        .o_side (w_d2_side)
    );

    // ---------------- back end: correction and saturation ----------------
    logic [48:0]        n_sum;
    logic [36:0]        n_mag;
    logic signed [37:0] r_p1_p, r_p2_p, r_p3_p;
    logic signed [24:0] n_e;
    logic signed [47:0] r_p2_ee;
    logic signed [53:0] r_p2_pp8;
    logic signed [63:0] r_p3_pe;
    logic signed [34:0] r_p3_v2;
    logic signed [63:0] r_p4_s;
    t_side              r_p_side [1:4];
    logic [31:0]        r_o_press;
    logic signed [15:0] r_o_tc;
    logic signed [24:0] r_o_tfine;
    logic               r_o_bad;

    always_comb begin
        n_sum = 49'(w_d2_side.qk) + 49'(w_d2_quo);
        n_mag = (w_d2_side.sat || (n_sum > 49'(QUOT_CLAMP))) ? QUOT_CLAMP : 37'(n_sum);
        n_e   = 25'(r_p1_p >>> 13);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_p      <= w_d2_side.neg ? -$signed({1'b0, n_mag}) : $signed({1'b0, n_mag});
            r_p_side[1] <= w_d2_side;
            for (int k = 2; k <= 4; k++) begin
                r_p_side[k] <= r_p_side[k-1];
            end
            r_p2_p   <= r_p1_p;
            r_p2_ee  <= n_e * n_e;
            r_p2_pp8 <= w_p8 * r_p1_p;
            r_p3_p   <= r_p2_p;
            r_p3_pe  <= w_p9 * r_p2_ee;
            r_p3_v2  <= 35'(r_p2_pp8 >>> 19);
            r_p4_s   <= ((64'(r_p3_p) + (r_p3_pe >>> 25) + 64'(r_p3_v2)) >>> 8)
                        + (64'(w_p7) <<< 4);
            // output register: drop to zero on a bad divisor, clamp to range
            if (r_p_side[4].bad || r_p4_s[63]) begin
                r_o_press <= '0;
            end else if (r_p4_s[62:32] != '0) begin
                r_o_press <= 32'hffff_ffff;
            end else begin
                r_o_press <= r_p4_s[31:0];
            end
            r_o_tc    <= r_p_side[4].tc;
            r_o_tfine <= r_p_side[4].tfine;
            r_o_bad   <= r_p_side[4].bad;
        end
    end

    assign m_axis_tvalid   = r_vld_p[5];
    assign m_axis_tdata    = {r_o_press, {7{r_o_tfine[24]}}, r_o_tfine, r_o_tc};
    assign m_axis_tuser[0] = r_o_bad;

    // ---------------- assertions ----------------
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[79:48] == 32'h0)
        else $error("invalid result carries nonzero pressure");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && r_vld_s == '0)
        else $error("pipeline not empty after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld_s) && $stable(r_vld_p) && $stable(r_vld_x))
        else $error("pipeline moved during stall");

    a_fine_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($countones(m_axis_tdata[47:40]) == 0)
                          || ($countones(m_axis_tdata[47:40]) == 8))
        else $error("fine temperature out of 25-bit range");

endmodule
